@@ rtl/servo_command_frame_encoder_defines.svh @@
// Assertion macros used by the byte serializer of the servo command frame encoder.
`ifndef SERVO_COMMAND_FRAME_ENCODER_DEFINES_SVH
`define SERVO_COMMAND_FRAME_ENCODER_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define SCFE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scfe assertion failed");

// Check that a condition implies another in the following cycle.
`define SCFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scfe assertion failed");

`endif

@@ rtl/scfe_pkg.sv @@
// Package with constants and types of the servo command frame encoder.
package scfe_pkg;

    localparam int unsigned FRAME_MAX = 9;
    localparam int unsigned COUNT_W   = 4;

    localparam logic [7:0] HEADER_BYTE  = 8'hFF;
    localparam logic [7:0] WRITE_LENGTH = 8'd5;
    localparam logic [7:0] READ_LENGTH  = 8'd4;
    localparam logic [7:0] WRITE_CODE_RST = 8'd3;
    localparam logic [7:0] READ_CODE_RST  = 8'd2;

    localparam logic [COUNT_W-1:0] WRITE_TOTAL = 4'd9;
    localparam logic [COUNT_W-1:0] READ_TOTAL  = 4'd8;

    // Request kinds
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Register indexes
    localparam logic REG_WRITE_CODE = 1'b0;
    localparam logic REG_READ_CODE  = 1'b1;

    typedef logic [7:0] byte_t;

    // Built frame handed from the builder to the serializer
    typedef struct packed {
        logic                  valid;
        logic [COUNT_W-1:0]    total;
        byte_t [FRAME_MAX-1:0] bytes;
    } frame_t;

    // Command bytes from the register block
    typedef struct packed {
        byte_t write_code;
        byte_t read_code;
    } codes_t;

endpackage

@@ rtl/scfe_cfg_regs.sv @@
// APB register block holding the write and read command codes.
module scfe_cfg_regs
    import scfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output codes_t      codes
);

    byte_t write_code_reg;
    byte_t read_code_reg;
    logic  wr_en;
    logic  reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    // Write a code on the access cycle of a write transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_code_reg <= WRITE_CODE_RST;
            read_code_reg  <= READ_CODE_RST;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_WRITE_CODE: write_code_reg <= pwdata[7:0];
                REG_READ_CODE:  read_code_reg  <= pwdata[7:0];
                default:        write_code_reg <= write_code_reg;
            endcase
        end
    end

    // Return the selected code on reads
    always_comb
    begin
        case (reg_sel)
            REG_WRITE_CODE: prdata = {24'd0, write_code_reg};
            REG_READ_CODE:  prdata = {24'd0, read_code_reg};
            default:        prdata = 32'd0;
        endcase
    end

    assign codes.write_code = write_code_reg;
    assign codes.read_code  = read_code_reg;

endmodule

@@ rtl/scfe_frame_builder.sv @@
// Request register and frame assembly with checksum.
module scfe_frame_builder
    import scfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        opcode,
    input  logic [7:0]  servo_id,
    input  logic [7:0]  reg_address,
    input  logic [15:0] write_value,
    input  logic [7:0]  read_count,
    input  codes_t      codes,
    input  logic        load,
    output logic        busy,
    output frame_t      frame
);

    logic        req_valid_reg;
    logic        req_valid_next;
    logic        op_reg;
    byte_t       id_reg;
    byte_t       addr_reg;
    logic [15:0] value_reg;
    byte_t       count_reg;
    logic        accept;
    byte_t       len_b;
    byte_t       code_b;
    byte_t       p1_b;
    byte_t       p2_b;
    byte_t       csum;

    assign busy   = req_valid_reg & ~load;
    assign accept = start & ~busy;

    // Hold a request until the serializer takes it
    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (accept)
            req_valid_next = 1'b1;
        else if (load)
            req_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else
            req_valid_reg <= req_valid_next;
    end

    // Capture the request fields on each accepted transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= opcode;
            id_reg    <= servo_id;
            addr_reg  <= reg_address;
            value_reg <= write_value;
            count_reg <= read_count;
        end
    end

    // Select length, command and parameters by request kind
    always_comb
    begin
        case (op_reg)
            OP_READ:
            begin
                len_b  = READ_LENGTH;
                code_b = codes.read_code;
                p1_b   = count_reg;
                p2_b   = 8'd0;
            end
            default:
            begin
                len_b  = WRITE_LENGTH;
                code_b = codes.write_code;
                p1_b   = value_reg[7:0];
                p2_b   = value_reg[15:8];
            end
        endcase
    end

    // Invert the low byte of the sum from id through the last parameter
    assign csum = ~(id_reg + len_b + code_b + addr_reg + p1_b + p2_b);

    // Lay out the frame bytes in transmit order
    always_comb
    begin
        frame.valid    = req_valid_reg;
        frame.bytes[0] = HEADER_BYTE;
        frame.bytes[1] = HEADER_BYTE;
        frame.bytes[2] = id_reg;
        frame.bytes[3] = len_b;
        frame.bytes[4] = code_b;
        frame.bytes[5] = addr_reg;
        frame.bytes[6] = p1_b;
        if (op_reg == OP_READ)
        begin
            frame.bytes[7] = csum;
            frame.bytes[8] = 8'd0;
            frame.total    = READ_TOTAL;
        end
        else
        begin
            frame.bytes[7] = p2_b;
            frame.bytes[8] = csum;
            frame.total    = WRITE_TOTAL;
        end
    end

endmodule

@@ rtl/scfe_byte_serializer.sv @@
// Frame shift register that emits one byte per cycle.
`include "servo_command_frame_encoder_defines.svh"

module scfe_byte_serializer
    import scfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  frame_t      frame,
    output logic        load,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic        frame_end
);

    byte_t [FRAME_MAX-1:0] shift_reg;
    byte_t [FRAME_MAX-1:0] shift_next;
    logic [COUNT_W-1:0]    left_reg;
    logic [COUNT_W-1:0]    left_next;

    // Take a new frame when idle or while the last byte goes out
    assign load = frame.valid & (left_reg <= COUNT_W'(1));

    // Advance the byte counter
    always_comb
    begin
        if (load)
            left_next = frame.total;
        else if (left_reg != '0)
            left_next = left_reg - COUNT_W'(1);
        else
            left_next = left_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            left_reg <= '0;
        else
            left_reg <= left_next;
    end

    // Load or shift the frame bytes toward the output slot
    always_comb
    begin
        shift_next = shift_reg;
        if (load)
            shift_next = frame.bytes;
        else
        begin
            for (int i = 0; i < FRAME_MAX - 1; i++)
                shift_next[i] = shift_reg[i + 1];
            shift_next[FRAME_MAX-1] = 8'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    assign tx_valid  = (left_reg != '0);
    assign tx_byte   = shift_reg[0];
    assign frame_end = (left_reg == COUNT_W'(1));

    `SCFE_ASSERT_SAME(a_load_at_end, clk, rst_n, load, left_reg <= COUNT_W'(1))
    `SCFE_ASSERT_NEXT(a_no_gap, clk, rst_n, tx_valid && !frame_end, tx_valid)
    `SCFE_ASSERT_NEXT(a_next_header, clk, rst_n, tx_valid && frame_end,
                      !tx_valid || tx_byte == HEADER_BYTE)
    `SCFE_ASSERT_NEXT(a_first_header, clk, rst_n, load, tx_byte == HEADER_BYTE)

endmodule

@@ rtl/servo_command_frame_encoder.sv @@
// Top level of the servo command frame encoder.
//
// Usage: drive one servo request on the field ports with start high; the
// request is taken at a rising edge where start is high and busy is low.
// The frame goes out on tx_byte one byte per cycle with tx_valid high for
// each byte; frame_end marks the checksum byte. A write frame is 9 bytes,
// a read frame 8 bytes.
// The accepted request is registered in the builder, then loaded into the
// byte shifter when it is free; the first header byte then shows on tx_byte.
// One request is held while a frame shifts out, so a new request can be
// taken before the last frame is through; the pace of frames is set by the
// one-byte-per-cycle shift register; frames follow each other with no gap.
// Command codes are set over the APB port: write_code at address 0,
// read_code at address 4; change them only while the block is idle.
// Reset clears the pending request and the byte counter and restores the
// codes to 3 and 2. The receiver cannot stall: each byte is valid for
// exactly one cycle.
module servo_command_frame_encoder
    import scfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [7:0]  servo_id,
    input  logic [7:0]  reg_address,
    input  logic [15:0] write_value,
    input  logic [7:0]  read_count,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic        frame_end,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    codes_t codes;
    frame_t frame;
    logic   load;

    scfe_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .codes   (codes)
    );

    scfe_frame_builder u_frame_builder (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .opcode      (opcode),
        .servo_id    (servo_id),
        .reg_address (reg_address),
        .write_value (write_value),
        .read_count  (read_count),
        .codes       (codes),
        .load        (load),
        .busy        (busy),
        .frame       (frame)
    );

    scfe_byte_serializer u_byte_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame     (frame),
        .load      (load),
        .tx_valid  (tx_valid),
        .tx_byte   (tx_byte),
        .frame_end (frame_end)
    );

endmodule
